// ===== hw/rtl/pixel_format_converter_assert.svh =====
// Assertion macros for the pixel format converter
`ifndef PIXEL_FORMAT_CONVERTER_ASSERT_SVH
`define PIXEL_FORMAT_CONVERTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PFC_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define PFC_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define PFC_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define PFC_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

// ===== hw/rtl/pfc_pkg.sv =====
// Package: modes, coefficients and pipeline depth
package pfc_pkg;
  localparam int unsigned NumStages = 4;

  typedef enum logic [3:0] {
    MODE_COPY = 4'd0, MODE_TO332 = 4'd1, MODE_FROM332 = 4'd2, MODE_TO565BE = 4'd3,
    MODE_TO565LE = 4'd4, MODE_FROM565BE = 4'd5, MODE_FROM565LE = 4'd6,
    MODE_YUV2RGB = 4'd7, MODE_RGB2YUV = 4'd8, MODE_YUV2YUYV = 4'd9,
    MODE_YUYV2YUV = 4'd10, MODE_RGB2YUYV = 4'd11, MODE_YUYV2RGB = 4'd12,
    MODE_GREY = 4'd13, MODE_Y82RGB = 4'd14, MODE_RGB2Y8 = 4'd15
  } mode_t;

  localparam logic signed [23:0] CY_R = 24'sd382939;
  localparam logic signed [23:0] CY_G = 24'sd1288070;
  localparam logic signed [23:0] CY_B = 24'sd130023;
  localparam logic signed [23:0] CU_R = -24'sd210973;
  localparam logic signed [23:0] CU_G = -24'sd710095;
  localparam logic signed [23:0] CU_B = 24'sd921069;
  localparam logic signed [23:0] CV_R = 24'sd921069;
  localparam logic signed [23:0] CV_G = -24'sd836553;
  localparam logic signed [23:0] CV_B = -24'sd84515;
  localparam logic signed [23:0] CR_Y = 24'sd2441923;
  localparam logic signed [23:0] CR_V = 24'sd3759774;
  localparam logic signed [23:0] CG_U = -24'sd447322;
  localparam logic signed [23:0] CG_V = -24'sd1117782;
  localparam logic signed [23:0] CB_U = 24'sd4430023;

  typedef struct packed {
    logic [7:0] byte0, byte1, byte2, byte3, byte4, byte5;
    logic       line_end;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] byte0, byte1, byte2, byte3, byte4, byte5;
    logic [2:0] count;
    logic       line_end;
  } pix_out_t;

  // floor shift by 21 then offset and clamp to 0..255
  function automatic logic [7:0] clamp_q21(input logic signed [35:0] acc,
                                           input logic signed [9:0] ofs);
    logic signed [15:0] v;
    v = 16'(acc >>> 21) + 16'(ofs);
    if (v < 0) return 8'd0;
    else if (v > 16'sd255) return 8'd255;
    else return v[7:0];
  endfunction
endpackage

// ===== hw/rtl/pfc_stream_if.sv =====
// Valid/ready stream interface carrying one payload
interface pfc_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/pfc_cfg_if.sv =====
// Configuration write channel
interface pfc_cfg_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [3:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/pixel_format_converter.sv =====
// Top level: four-stage pixel format converter
//  channel | dir | payload
//  in      | in  | six bytes + line end
//  out     | out | six bytes, count, line end
//  cfg     | in  | 4-bit conversion mode
// One beat per cycle unless the output stalls; stages in order: decode, multiply, sum, clamp/pack.
// The multiply stage forms the 24x10 coefficient products for both pixels of a beat.
// Synchronous active-low reset clears valid bits and the mode.
// A stall at the output freezes every stage that holds a beat; bubbles fill.
`include "pixel_format_converter_assert.svh"
module pixel_format_converter (
  input  logic clk,
  input  logic rst_n,
  pfc_stream_if.sink   in_s,
  pfc_stream_if.source out_s,
  pfc_cfg_if.sink      cfg_s
);
  import pfc_pkg::*;

  logic [3:0] mode_r;
  assign cfg_s.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= MODE_COPY;
    else if (cfg_s.valid) mode_r <= cfg_s.data;
  end

  logic [NumStages-1:0] vld_r;
  logic [NumStages-1:0] adv;
  always_comb begin
    adv[NumStages-1] = !vld_r[NumStages-1] || out_s.ready;
    for (int i = NumStages - 2; i >= 0; i--) adv[i] = !vld_r[i] || adv[i+1];
  end
  assign in_s.ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else begin
      if (adv[0]) vld_r[0] <= in_s.valid;
      for (int i = 1; i < NumStages; i++) if (adv[i]) vld_r[i] <= vld_r[i-1];
    end
  end

  // stage 1: pick operands for the two coefficient triples
  logic [3:0]  m1_r;
  pix_in_t     p1_r;
  logic signed [9:0] a_r [3], c_r [3];
  logic signed [9:0] a_nxt [3], c_nxt [3];
  always_comb begin
    pix_in_t d;
    d = in_s.data;
    for (int k = 0; k < 3; k++) begin
      a_nxt[k] = '0; c_nxt[k] = '0;
    end
    case (mode_r)
      MODE_RGB2YUV, MODE_RGB2YUYV, MODE_RGB2Y8: begin
        a_nxt[0] = {2'b0, d.byte0}; a_nxt[1] = {2'b0, d.byte1}; a_nxt[2] = {2'b0, d.byte2};
        c_nxt[0] = {2'b0, d.byte3}; c_nxt[1] = {2'b0, d.byte4}; c_nxt[2] = {2'b0, d.byte5};
      end
      // a = (y0,u,v) and, for YUYV only, c = (y1,u,v), offsets removed
      MODE_YUV2RGB: begin
        a_nxt[0] = {2'b0, d.byte0} - 10'sd16;
        a_nxt[1] = {2'b0, d.byte1} - 10'sd128;
        a_nxt[2] = {2'b0, d.byte2} - 10'sd128;
      end
      MODE_YUYV2RGB: begin
        a_nxt[0] = {2'b0, d.byte0} - 10'sd16;
        a_nxt[1] = {2'b0, d.byte1} - 10'sd128;
        a_nxt[2] = {2'b0, d.byte3} - 10'sd128;
        c_nxt[0] = {2'b0, d.byte2} - 10'sd16;
        c_nxt[1] = a_nxt[1]; c_nxt[2] = a_nxt[2];
      end
      MODE_Y82RGB: a_nxt[0] = {2'b0, d.byte0} - 10'sd16;
      default: ;
    endcase
  end
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      m1_r <= mode_r; p1_r <= in_s.data;
      for (int k = 0; k < 3; k++) begin
        a_r[k] <= a_nxt[k]; c_r[k] <= c_nxt[k];
      end
    end
  end

  // stage 2: products. pa: Y,U,V or R,G,B terms of first pixel; pc second.
  logic [3:0] m2_r;
  pix_in_t    p2_r;
  logic signed [35:0] pa_r [9], pc_r [9];
  logic rgb2;
  assign rgb2 = (m1_r == MODE_RGB2YUV) || (m1_r == MODE_RGB2YUYV) || (m1_r == MODE_RGB2Y8);
  function automatic logic signed [35:0] mul(input logic signed [23:0] k,
                                             input logic signed [9:0] x);
    return 36'(k) * 36'(x);
  endfunction
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      m2_r <= m1_r; p2_r <= p1_r;
      if (rgb2) begin
        pa_r[0] <= mul(CY_R, a_r[0]); pa_r[1] <= mul(CY_G, a_r[1]); pa_r[2] <= mul(CY_B, a_r[2]);
        pa_r[3] <= mul(CU_R, a_r[0]); pa_r[4] <= mul(CU_G, a_r[1]); pa_r[5] <= mul(CU_B, a_r[2]);
        pa_r[6] <= mul(CV_R, a_r[0]); pa_r[7] <= mul(CV_G, a_r[1]); pa_r[8] <= mul(CV_B, a_r[2]);
        pc_r[0] <= mul(CY_R, c_r[0]); pc_r[1] <= mul(CY_G, c_r[1]); pc_r[2] <= mul(CY_B, c_r[2]);
        pc_r[3] <= '0; pc_r[4] <= '0; pc_r[5] <= '0;
        pc_r[6] <= mul(CV_R, c_r[0]); pc_r[7] <= mul(CV_G, c_r[1]); pc_r[8] <= mul(CV_B, c_r[2]);
      end else begin
        pa_r[0] <= mul(CR_Y, a_r[0]); pa_r[1] <= '0;                 pa_r[2] <= mul(CR_V, a_r[2]);
        pa_r[3] <= mul(CR_Y, a_r[0]);
        pa_r[4] <= mul(CG_U, a_r[1]); pa_r[5] <= mul(CG_V, a_r[2]);
        pa_r[6] <= mul(CR_Y, a_r[0]); pa_r[7] <= mul(CB_U, a_r[1]); pa_r[8] <= '0;
        pc_r[0] <= mul(CR_Y, c_r[0]); pc_r[1] <= '0;                 pc_r[2] <= mul(CR_V, c_r[2]);
        pc_r[3] <= mul(CR_Y, c_r[0]);
        pc_r[4] <= mul(CG_U, c_r[1]); pc_r[5] <= mul(CG_V, c_r[2]);
        pc_r[6] <= mul(CR_Y, c_r[0]); pc_r[7] <= mul(CB_U, c_r[1]); pc_r[8] <= '0;
      end
    end
  end

  // stage 3: three-term sums
  logic [3:0] m3_r;
  pix_in_t    p3_r;
  logic signed [35:0] sa_r [3], sc_r [3];
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      m3_r <= m2_r; p3_r <= p2_r;
      for (int k = 0; k < 3; k++) begin
        sa_r[k] <= pa_r[3*k] + pa_r[3*k+1] + pa_r[3*k+2];
        sc_r[k] <= pc_r[3*k] + pc_r[3*k+1] + pc_r[3*k+2];
      end
    end
  end

  // stage 4: clamp and byte packing
  pix_out_t o_r, o_nxt;
  always_comb begin
    logic [7:0]  ya, ua, va, yc, vc, ra, ga, ba, rc, gc, bc;
    logic [15:0] w;
    pix_in_t     b;
    b  = p3_r;
    ya = clamp_q21(sa_r[0], 10'sd16);  ua = clamp_q21(sa_r[1], 10'sd128);
    va = clamp_q21(sa_r[2], 10'sd128); yc = clamp_q21(sc_r[0], 10'sd16);
    vc = clamp_q21(sc_r[2], 10'sd128);
    ra = clamp_q21(sa_r[0], 10'sd0); ga = clamp_q21(sa_r[1], 10'sd0);
    ba = clamp_q21(sa_r[2], 10'sd0); rc = clamp_q21(sc_r[0], 10'sd0);
    gc = clamp_q21(sc_r[1], 10'sd0); bc = clamp_q21(sc_r[2], 10'sd0);
    w  = {b.byte0[7:3], b.byte1[7:2], b.byte2[7:3]};
    o_nxt = '0;
    o_nxt.line_end = b.line_end;
    o_nxt.count = 3'd3;
    case (m3_r)
      MODE_COPY: begin
        o_nxt.byte0 = b.byte0; o_nxt.byte1 = b.byte1; o_nxt.byte2 = b.byte2;
      end
      MODE_TO332: begin
        o_nxt.byte0 = {b.byte0[7:5], b.byte1[7:5], b.byte2[7:6]}; o_nxt.count = 3'd1;
      end
      MODE_FROM332: begin
        o_nxt.byte0 = {b.byte0[7:5], 5'd0}; o_nxt.byte1 = {b.byte0[4:2], 5'd0};
        o_nxt.byte2 = {b.byte0[1:0], 6'd0};
      end
      MODE_TO565BE: begin
        o_nxt.byte0 = w[15:8]; o_nxt.byte1 = w[7:0]; o_nxt.count = 3'd2;
      end
      MODE_TO565LE: begin
        o_nxt.byte0 = w[7:0]; o_nxt.byte1 = w[15:8]; o_nxt.count = 3'd2;
      end
      MODE_FROM565BE: begin
        o_nxt.byte0 = {b.byte0[7:3], 3'd0};
        o_nxt.byte1 = {b.byte0[2:0], b.byte1[7:5], 2'd0};
        o_nxt.byte2 = {b.byte1[4:0], 3'd0};
      end
      MODE_FROM565LE: begin
        o_nxt.byte0 = {b.byte1[7:3], 3'd0};
        o_nxt.byte1 = {b.byte1[2:0], b.byte0[7:5], 2'd0};
        o_nxt.byte2 = {b.byte0[4:0], 3'd0};
      end
      MODE_YUV2RGB, MODE_Y82RGB: begin
        o_nxt.byte0 = ra; o_nxt.byte1 = ga; o_nxt.byte2 = ba;
      end
      MODE_RGB2YUV: begin
        o_nxt.byte0 = ya; o_nxt.byte1 = ua; o_nxt.byte2 = va;
      end
      MODE_YUV2YUYV: begin
        o_nxt.byte0 = b.byte0; o_nxt.byte1 = b.byte1; o_nxt.byte2 = b.byte3;
        o_nxt.byte3 = b.byte5; o_nxt.count = 3'd4;
      end
      MODE_YUYV2YUV: begin
        o_nxt.byte0 = b.byte0; o_nxt.byte1 = b.byte1; o_nxt.byte2 = b.byte3;
        o_nxt.byte3 = b.byte2; o_nxt.byte4 = b.byte1; o_nxt.byte5 = b.byte3;
        o_nxt.count = 3'd6;
      end
      MODE_RGB2YUYV: begin
        o_nxt.byte0 = ya; o_nxt.byte1 = ua; o_nxt.byte2 = yc; o_nxt.byte3 = vc;
        o_nxt.count = 3'd4;
      end
      MODE_YUYV2RGB: begin
        o_nxt.byte0 = ra; o_nxt.byte1 = ga; o_nxt.byte2 = ba;
        o_nxt.byte3 = rc; o_nxt.byte4 = gc; o_nxt.byte5 = bc; o_nxt.count = 3'd6;
      end
      MODE_GREY: begin
        o_nxt.byte0 = b.byte0; o_nxt.byte1 = b.byte0; o_nxt.byte2 = b.byte0;
      end
      default: begin
        o_nxt.byte0 = ya; o_nxt.count = 3'd1;
      end
    endcase
  end
  always_ff @(posedge clk) begin
    if (adv[3]) o_r <= o_nxt;
  end

  assign out_s.valid = vld_r[NumStages-1];
  assign out_s.data  = o_r;

  `PFC_ASSERT_NXT(a_stall_hold, clk, rst_n, out_s.valid && !out_s.ready, out_s.valid && $stable(out_s.data), "stalled beat changed")
  `PFC_ASSERT_IMP(a_count_range, clk, rst_n, out_s.valid, out_s.data.count >= 3'd1 && out_s.data.count <= 3'd6, "bad count")
  `PFC_ASSERT_IMP(a_ready_free, clk, rst_n, !vld_r[0], in_s.ready, "empty front stage not ready")
endmodule

// ===== test/tb_top.sv =====
// Testbench for the pixel format converter: directed table, random beats, scoreboard
`timescale 1ns / 1ps
module tb_top;
  import pfc_pkg::*;

  localparam int CycleLimit = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #10 clk = ~clk;

  pfc_stream_if #(.payload_t(pix_in_t))  in_s  (clk);
  pfc_stream_if #(.payload_t(pix_out_t)) out_s (clk);
  pfc_cfg_if                             cfg_s (clk);

  pixel_format_converter i_dut (
    .clk(clk), .rst_n(rst_n), .in_s(in_s.sink), .out_s(out_s.source), .cfg_s(cfg_s.sink)
  );

  mode_t    cur_mode;
  pix_out_t pending_px[$];
  int       errors = 0;
  int       cycles = 0;
  int       send_idle = 0;
  int       recv_stall = 0;

  initial begin
    in_s.valid = 1'b0;
    in_s.data = '0;
    out_s.ready = 1'b0;
    cfg_s.valid = 1'b0;
    cfg_s.data = '0;
  end

  // floor of a Q21 product sum, offset, clamp to a byte
  function automatic logic [7:0] sat_q21(longint acc, longint ofs);
    longint v;
    v = (acc >>> 21) + ofs;
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic logic [7:0] calc_y(longint r, longint g, longint b);
    return sat_q21(382939 * r + 1288070 * g + 130023 * b, 16);
  endfunction

  function automatic logic [7:0] calc_u(longint r, longint g, longint b);
    return sat_q21(-210973 * r - 710095 * g + 921069 * b, 128);
  endfunction

  function automatic logic [7:0] calc_v(longint r, longint g, longint b);
    return sat_q21(921069 * r - 836553 * g - 84515 * b, 128);
  endfunction

  function automatic logic [23:0] yuv_rgb(longint y, longint u, longint v);
    longint yy, uu, vv;
    yy = y - 16;
    uu = u - 128;
    vv = v - 128;
    return {sat_q21(2441923 * yy + 3759774 * vv, 0),
            sat_q21(2441923 * yy - 447322 * uu - 1117782 * vv, 0),
            sat_q21(2441923 * yy + 4430023 * uu, 0)};
  endfunction

  function automatic logic [23:0] unpack_565(logic [15:0] w);
    logic [7:0] r, g, b;
    r = {w[15:11], 3'd0};
    g = {w[10:5], 2'd0};
    b = {w[4:0], 3'd0};
    return {r, g, b};
  endfunction

  function automatic pix_out_t convert_px(mode_t m, pix_in_t p);
    pix_out_t o;
    logic [7:0] b0, b1, b2, b3, b4, b5;
    logic [15:0] w;
    b0 = p.byte0; b1 = p.byte1; b2 = p.byte2;
    b3 = p.byte3; b4 = p.byte4; b5 = p.byte5;
    o = '0;
    o.count = 3'd3;
    o.line_end = p.line_end;
    w = {b0[7:3], b1[7:2], b2[7:3]};
    case (m)
      MODE_COPY: {o.byte0, o.byte1, o.byte2} = {b0, b1, b2};
      MODE_TO332: begin
        o.byte0 = {b0[7:5], b1[7:5], b2[7:6]};
        o.count = 3'd1;
      end
      MODE_FROM332: begin
        o.byte0 = {b0[7:5], 5'd0};
        o.byte1 = {b0[4:2], 5'd0};
        o.byte2 = {b0[1:0], 6'd0};
      end
      MODE_TO565BE: begin
        {o.byte0, o.byte1} = w;
        o.count = 3'd2;
      end
      MODE_TO565LE: begin
        {o.byte1, o.byte0} = w;
        o.count = 3'd2;
      end
      MODE_FROM565BE: {o.byte0, o.byte1, o.byte2} = unpack_565({b0, b1});
      MODE_FROM565LE: {o.byte0, o.byte1, o.byte2} = unpack_565({b1, b0});
      MODE_YUV2RGB: {o.byte0, o.byte1, o.byte2} = yuv_rgb(b0, b1, b2);
      MODE_RGB2YUV: begin
        o.byte0 = calc_y(b0, b1, b2);
        o.byte1 = calc_u(b0, b1, b2);
        o.byte2 = calc_v(b0, b1, b2);
      end
      MODE_YUV2YUYV: begin
        {o.byte0, o.byte1, o.byte2, o.byte3} = {b0, b1, b3, b5};
        o.count = 3'd4;
      end
      MODE_YUYV2YUV: begin
        {o.byte0, o.byte1, o.byte2, o.byte3, o.byte4, o.byte5} = {b0, b1, b3, b2, b1, b3};
        o.count = 3'd6;
      end
      MODE_RGB2YUYV: begin
        o.byte0 = calc_y(b0, b1, b2);
        o.byte1 = calc_u(b0, b1, b2);
        o.byte2 = calc_y(b3, b4, b5);
        o.byte3 = calc_v(b3, b4, b5);
        o.count = 3'd4;
      end
      MODE_YUYV2RGB: begin
        {o.byte0, o.byte1, o.byte2} = yuv_rgb(b0, b1, b3);
        {o.byte3, o.byte4, o.byte5} = yuv_rgb(b2, b1, b3);
        o.count = 3'd6;
      end
      MODE_GREY: {o.byte0, o.byte1, o.byte2} = {b0, b0, b0};
      MODE_Y82RGB: {o.byte0, o.byte1, o.byte2} = yuv_rgb(b0, 128, 128);
      default: begin
        o.byte0 = calc_y(b0, b1, b2);
        o.count = 3'd1;
      end
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d (mode %0d)", what, got, want, cur_mode);
    errors++;
  endtask

  // receiver: stall pattern and scoreboard
  always @(posedge clk) begin
    pix_out_t e, g;
    cycles <= cycles + 1;
    if (rst_n && out_s.valid && out_s.ready) begin
      g = out_s.data;
      if (pending_px.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        e = pending_px.pop_front();
        if (g.byte0 !== e.byte0) report_mismatch("byte0", g.byte0, e.byte0);
        if (g.byte1 !== e.byte1) report_mismatch("byte1", g.byte1, e.byte1);
        if (g.byte2 !== e.byte2) report_mismatch("byte2", g.byte2, e.byte2);
        if (g.byte3 !== e.byte3) report_mismatch("byte3", g.byte3, e.byte3);
        if (g.byte4 !== e.byte4) report_mismatch("byte4", g.byte4, e.byte4);
        if (g.byte5 !== e.byte5) report_mismatch("byte5", g.byte5, e.byte5);
        if (g.count !== e.count) report_mismatch("count", g.count, e.count);
        if (g.line_end !== e.line_end) report_mismatch("line_end", g.line_end, e.line_end);
      end
    end
    out_s.ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("timeout");
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_mode(mode_t m);
    cfg_s.valid <= 1'b1;
    cfg_s.data <= m;
    do @(posedge clk); while (!cfg_s.ready);
    cur_mode = m;
    cfg_s.valid <= 1'b0;
  endtask

  task automatic send_px(pix_in_t p);
    while ($urandom_range(99) < send_idle) begin
      in_s.valid <= 1'b0;
      @(posedge clk);
    end
    in_s.valid <= 1'b1;
    in_s.data <= p;
    do @(posedge clk); while (!in_s.ready);
    pending_px.push_back(convert_px(cur_mode, p));
  endtask

  task automatic drain_out;
    in_s.valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (NumStages + 2) @(posedge clk);
  endtask

  function automatic pix_in_t rand_px();
    pix_in_t p;
    p = 49'({$urandom, $urandom});
    if ($urandom_range(9) == 0) p.byte0 = ($urandom_range(1)) ? 8'hff : 8'h00;
    return p;
  endfunction

  typedef struct {
    mode_t    m;
    pix_in_t  p;
    bit       typed;
    pix_out_t want;
  } dir_row_t;

  dir_row_t rows[$];

  initial begin
    pix_out_t got_e;
    int n;
    rows.push_back('{MODE_COPY, {48'hff00ff_123456, 1'b1}, 1, {48'hff00ff_000000, 3'd3, 1'b1}});
    rows.push_back('{MODE_COPY, {48'h000000_ffffff, 1'b0}, 1, {48'h000000_000000, 3'd3, 1'b0}});
    rows.push_back('{MODE_TO332, {48'hffffff_ffffff, 1'b1}, 1, {48'hff0000_000000, 3'd1, 1'b1}});
    rows.push_back('{MODE_TO332, {48'h000000_000000, 1'b0}, 1, {48'h0, 3'd1, 1'b0}});
    rows.push_back('{MODE_FROM332, {48'hff0000_000000, 1'b0}, 1, {48'he0e0c0_000000, 3'd3, 1'b0}});
    rows.push_back('{MODE_TO565BE, {48'hffffff_000000, 1'b0}, 1, {48'hffff00_000000, 3'd2, 1'b0}});
    rows.push_back('{MODE_TO565LE, {48'hff0000_000000, 1'b1}, 1, {48'h00f800_000000, 3'd2, 1'b1}});
    rows.push_back('{MODE_FROM565BE, {48'hffff00_000000, 1'b0}, 1, {48'hf8fcf8_000000, 3'd3, 1'b0}});
    rows.push_back('{MODE_FROM565LE, {48'h00f800_000000, 1'b0}, 1, {48'hf80000_000000, 3'd3, 1'b0}});
    rows.push_back('{MODE_YUV2RGB, {48'h108080_000000, 1'b0}, 1, {48'h000000_000000, 3'd3, 1'b0}});
    rows.push_back('{MODE_YUV2RGB, {48'hffffff_000000, 1'b1}, 0, '0});
    rows.push_back('{MODE_YUV2RGB, {48'h000000_000000, 1'b0}, 0, '0});
    rows.push_back('{MODE_RGB2YUV, {48'h000000_000000, 1'b0}, 1, {48'h108080_000000, 3'd3, 1'b0}});
    rows.push_back('{MODE_RGB2YUV, {48'hff00ff_000000, 1'b0}, 0, '0});
    rows.push_back('{MODE_YUV2YUYV, {48'h112233_445566, 1'b1}, 1, {48'h112244_660000, 3'd4, 1'b1}});
    rows.push_back('{MODE_YUYV2YUV, {48'h112233_44ffff, 1'b0}, 1, {48'h112244_332244, 3'd6, 1'b0}});
    rows.push_back('{MODE_RGB2YUYV, {48'hff0000_0000ff, 1'b0}, 0, '0});
    rows.push_back('{MODE_RGB2YUYV, {48'hffffff_000000, 1'b1}, 0, '0});
    rows.push_back('{MODE_YUYV2RGB, {48'heb00ff_ff0000, 1'b0}, 0, '0});
    rows.push_back('{MODE_YUYV2RGB, {48'h10ff10_00ffff, 1'b1}, 0, '0});
    rows.push_back('{MODE_GREY, {48'h7f0102_030405, 1'b1}, 1, {48'h7f7f7f_000000, 3'd3, 1'b1}});
    rows.push_back('{MODE_Y82RGB, {48'hff0000_000000, 1'b0}, 0, '0});
    rows.push_back('{MODE_Y82RGB, {48'h000000_000000, 1'b0}, 0, '0});
    rows.push_back('{MODE_RGB2Y8, {48'hffffff_000000, 1'b0}, 0, '0});
    rows.push_back('{MODE_RGB2Y8, {48'h000000_000000, 1'b1}, 1, {48'h100000_000000, 3'd1, 1'b1}});

    cur_mode = MODE_COPY;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first row runs on the mode left by reset
    foreach (rows[i]) begin
      if (i > 0 && rows[i].m != cur_mode) begin
        drain_out();
        write_mode(rows[i].m);
      end
      n = pending_px.size();
      send_px(rows[i].p);
      if (rows[i].typed) begin
        got_e = pending_px[n];
        if (got_e !== rows[i].want) begin
          $display("predictor disagrees with table at row %0d", i);
          errors++;
        end
        pending_px[n] = rows[i].want;
      end
    end
    drain_out();

    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 64; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 64; end
        default: begin send_idle = 22; recv_stall = 22; end
      endcase
      write_mode(mode_t'((ph * 7) % 16));
      repeat (40) send_px(rand_px());
      drain_out();
    end

    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/pfc_pkg.sv
hw/rtl/pfc_stream_if.sv
hw/rtl/pfc_cfg_if.sv
hw/rtl/pixel_format_converter.sv
test/tb_top.sv
